### rtl/core/wpm_pkg.sv
// Shared constants and types for the wildcard pattern matcher.
// Used by wpm_cell and wildcard_pattern_match_top; depends on nothing.
package wpm_pkg;

   // Pattern geometry
   localparam int PATTERN_MAX   = 32;
   localparam int CHAR_W        = 8;
   localparam int LEN_W         = 6;
   localparam int POS_W         = $clog2(PATTERN_MAX + 1);
   localparam int BYTES_PER_REG = 8;
   localparam int NUM_PAT_REGS  = 4;
   localparam int REG_BYTES     = BYTES_PER_REG * NUM_PAT_REGS;

   // Configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BYTES_A = 3'd1;

   // Wildcard characters
   localparam logic [CHAR_W-1:0] ANY_ONE = 8'h3F;  // '?'
   localparam logic [CHAR_W-1:0] ANY_RUN = 8'h2A;  // '*'

   // Signals handed from one cell to the next
   typedef struct packed {
      logic step;   // position advanced by one character
      logic init;   // start vector, closed over leading stars
      logic close;  // star closure ripple
   } link_type;

endpackage

### rtl/core/wpm_cell.sv
// One pattern position of the matcher: holds one active bit and
// compares its pattern byte. Depends on wpm_pkg.
module wpm_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [wpm_pkg::CHAR_W-1:0]   pat_char,
   input  logic [wpm_pkg::CHAR_W-1:0]   char_code,
   input  logic                         in_use,
   input  logic                         inside_word,
   input  logic                         load,
   input  logic                         clear,
   input  wpm_pkg::link_type            link_in,
   output wpm_pkg::link_type            link_out,
   output logic                         next_bit,
   output logic                         init_bit,
   output logic                         active
);

   logic active_ff;
   logic active_in;
   logic is_star;
   logic is_hit;
   logic cur;
   logic keep;
   logic next_raw;
   logic next_closed;

   // Pattern byte classification
   assign is_star = (pat_char == wpm_pkg::ANY_RUN);
   assign is_hit  = (pat_char == wpm_pkg::ANY_ONE) || (pat_char == char_code);

   // Current bit: stored state inside a word, else the start vector
   assign cur = inside_word ? active_ff : link_in.init;

   // Advance by one character, then close over stars
   assign keep        = cur & in_use & is_star;
   assign next_raw    = keep | link_in.step;
   assign next_closed = next_raw | link_in.close;

   assign link_out.init  = link_in.init & in_use & is_star;
   assign link_out.step  = cur & in_use & ~is_star & is_hit;
   assign link_out.close = next_closed & in_use & is_star;

   assign next_bit = next_closed;
   assign init_bit = link_in.init;
   assign active   = active_ff;

   // State update
   always_comb begin
      active_in = active_ff;
      if (clear) begin
         active_in = 1'b0;
      end else if (load) begin
         active_in = next_closed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

### rtl/core/wildcard_pattern_match_top.sv
// Top level of the wildcard pattern matcher: configuration registers,
// the row of wpm_cell positions and the result register. Depends on wpm_pkg.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  request | req_valid/req_ready, char_code, last, empty   | in
//  result  | rsp_valid/rsp_ready, rsp_matched             | out
//  config  | csr_we, csr_index, csr_wdata                 | in
//
// One request per cycle; a word's result appears the cycle after its last
// request. The advance and star closure ripple through the cell row combinationally.
// Synchronous active-high reset clears the pattern, the active bits and valid.
// Requests that end a word wait only while a result is held and not taken.
module wildcard_pattern_match_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wpm_pkg::CHAR_W-1:0]        req_char_code,
   input  logic                              req_last_char,
   input  logic                              req_empty_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_matched,
   input  logic                              csr_we,
   input  logic [wpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wpm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PMAX = wpm_pkg::PATTERN_MAX;

   logic [wpm_pkg::LEN_W-1:0]  pattern_length_ff;
   logic [wpm_pkg::CHAR_W-1:0] pat_ff [PMAX];
   logic                       inside_word_ff;
   logic                       inside_word_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_matched_ff;
   logic                       rsp_matched_in;

   logic [wpm_pkg::POS_W-1:0]  len_eff;
   logic [PMAX-1:0]            in_use;
   wpm_pkg::link_type          link [PMAX+1];
   logic [PMAX:0]              next_vec;
   logic [PMAX:0]              init_vec;
   logic [PMAX-1:0]            active_vec;
   logic                       req_fire;
   logic                       word_end;
   logic                       load;
   logic                       clear;
   logic                       result;

   // Effective pattern length, clamped to the cell count
   assign len_eff = (pattern_length_ff > wpm_pkg::LEN_W'(PMAX)) ?
                    wpm_pkg::POS_W'(PMAX) : wpm_pkg::POS_W'(pattern_length_ff);

   // Handshake and control
   assign word_end  = req_last_char | req_empty_word;
   assign req_ready = rsp_ready | ~rsp_valid_ff | ~word_end;
   assign req_fire  = req_valid & req_ready;
   assign load      = req_fire & ~word_end;
   assign clear     = req_fire & word_end;

   // Pattern length register
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
      end else if (csr_we && csr_index == wpm_pkg::REG_PATTERN_LENGTH) begin
         pattern_length_ff <= csr_wdata[wpm_pkg::LEN_W-1:0];
      end
   end

   // Cell row seed: start at prefix zero, nothing advancing or closing
   assign link[0].step  = 1'b0;
   assign link[0].init  = 1'b1;
   assign link[0].close = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < PMAX; gi++) begin : g_pos
         // Pattern byte: written through its byte lane, or fixed at zero
         if (gi < wpm_pkg::REG_BYTES) begin : g_byte
            localparam logic [wpm_pkg::CSR_IDX_W-1:0] RegIdx =
               wpm_pkg::REG_PATTERN_BYTES_A +
               wpm_pkg::CSR_IDX_W'(gi / wpm_pkg::BYTES_PER_REG);
            localparam int Lane = gi % wpm_pkg::BYTES_PER_REG;
            always_ff @(posedge clock) begin
               if (reset) begin
                  pat_ff[gi] <= '0;
               end else if (csr_we && csr_index == RegIdx) begin
                  pat_ff[gi] <= csr_wdata[Lane*wpm_pkg::CHAR_W +: wpm_pkg::CHAR_W];
               end
            end
         end else begin : g_zero
            assign pat_ff[gi] = '0;
         end

         assign in_use[gi] = wpm_pkg::POS_W'(gi) < len_eff;

         wpm_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .pat_char    (pat_ff[gi]),
            .char_code   (req_char_code),
            .in_use      (in_use[gi]),
            .inside_word (inside_word_ff),
            .load        (load),
            .clear       (clear),
            .link_in     (link[gi]),
            .link_out    (link[gi+1]),
            .next_bit    (next_vec[gi]),
            .init_bit    (init_vec[gi]),
            .active      (active_vec[gi])
         );
      end
   endgenerate

   // Position past the last cell
   assign next_vec[PMAX] = link[PMAX].step | link[PMAX].close;
   assign init_vec[PMAX] = link[PMAX].init;

   // Word match: is the full pattern length reached
   assign result = req_empty_word ? init_vec[len_eff] : next_vec[len_eff];

   // Word tracking and result register
   always_comb begin
      inside_word_in = inside_word_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (clear) begin
         inside_word_in = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_matched_in = result;
      end else if (load) begin
         inside_word_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_word_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         inside_word_ff <= inside_word_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

`ifndef ASSERT_OFF
   // A word-ending request always produces a result next cycle
   a_end_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_last_char || req_empty_word)) |=> rsp_valid)
      else $error("word end did not produce a result");

   // Word-ending request leaves the block outside a word
   a_end_clears_word : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_last_char || req_empty_word)) |=> !inside_word_ff)
      else $error("word still open after its end");

   // A middle character opens or continues a word
   a_mid_sets_word : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last_char && !req_empty_word) |=> inside_word_ff)
      else $error("word not tracked after a middle character");

   // Outside a word no position is active
   a_idle_no_active : assert property (@(posedge clock) disable iff (reset)
      !inside_word_ff |-> (active_vec == '0))
      else $error("active positions left outside a word");

   // Input stalls only behind an untaken result
   a_ready_reason : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a held result");
`endif

endmodule
